### design/median_window_filter_assert.svh
// ----------------------------------------------------------------------------
// median window filter assertion macros
// shared property forms for the filter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MEDIAN_WINDOW_FILTER_ASSERT_SVH
`define MEDIAN_WINDOW_FILTER_ASSERT_SVH

// same-cycle implication
`define MWF_ASSERT_NOW(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("median_window_filter: check failed");

// next-cycle implication
`define MWF_ASSERT_NEXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("median_window_filter: check failed");

`endif

### design/medf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medf_pkg
// shared widths, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package medf_pkg;

  localparam int PIX_W     = 8;
  localparam int WS_W      = 4;
  localparam int DIM_W     = 11;
  localparam int RAD_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd2;

  localparam logic [WS_W-1:0]  WS_RESET   = 4'd3;
  localparam logic [DIM_W-1:0] COLS_RESET = 11'd640;
  localparam logic [DIM_W-1:0] ROWS_RESET = 11'd480;

  localparam logic CMD_PIXEL = 1'b0;

  typedef struct packed {
    logic accept;
    logic scan;
    logic shift;
    logic load_out;
  } medf_cmd_t;

  typedef struct packed {
    logic emit;
    logic scan_last;
    logic sel_done;
    logic out_free;
  } medf_status_t;

endpackage

### design/medf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medf_ctrl
// sequencer: input beat, window scan, sorted-list select, result load
// ----------------------------------------------------------------------------
`include "median_window_filter_assert.svh"

module medf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  medf_pkg::medf_status_t status,
  output medf_pkg::medf_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_SEL   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.emit) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_SEL;
      end
      S_SEL: begin
        if (!status.sel_done) begin
          cmd.shift = 1'b1;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MWF_ASSERT_NEXT(a_scan_to_drain, clk, rst, state == S_SCAN && status.scan_last, state == S_DRAIN)
  `MWF_ASSERT_NEXT(a_drain_to_sel, clk, rst, state == S_DRAIN, state == S_SEL)
  `MWF_ASSERT_NOW(a_load_free, clk, rst, cmd.load_out, status.out_free && status.sel_done)
  `MWF_ASSERT_NEXT(a_load_idle, clk, rst, cmd.load_out, state == S_IDLE)

endmodule

### design/medf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medf_dp
// config registers, position counters, row ring memory, window scan,
// insertion sorter and output register
// ----------------------------------------------------------------------------
module medf_dp #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_WINDOW = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [medf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [medf_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            command,
  input  logic [medf_pkg::PIX_W-1:0]      pixel_in,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [medf_pkg::PIX_W-1:0]      pixel_out,
  output logic                            frame_end,
  input  medf_pkg::medf_cmd_t             cmd,
  output medf_pkg::medf_status_t          status
);

  localparam int RING  = 2 * MAX_WINDOW;
  localparam int RGW   = $clog2(RING);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CV    = $clog2(MAX_COLS + 1);
  localparam int RV    = $clog2(MAX_ROWS + 1);
  localparam int IRW   = $clog2(MAX_ROWS + MAX_WINDOW + 1);
  localparam int PW    = $clog2(MAX_COLS * MAX_ROWS + MAX_WINDOW * MAX_COLS + MAX_WINDOW + 1);
  localparam int RMAX  = MAX_WINDOW >> 1;
  localparam int SPW   = medf_pkg::RAD_W + 1;
  localparam int WIN   = MAX_WINDOW * MAX_WINDOW;
  localparam int NW    = $clog2(WIN + 1);
  localparam int XW    = CV + 2;
  localparam int YW    = RV + 2;
  localparam int DEPTH = RING * (2 ** CW);
  localparam int I1    = (WIN > 1) ? 1 : 0;
  localparam int PX    = medf_pkg::PIX_W;

  logic [medf_pkg::WS_W-1:0]  window_size;
  logic [medf_pkg::DIM_W-1:0] image_cols;
  logic [medf_pkg::DIM_W-1:0] image_rows;

  logic [medf_pkg::RAD_W-1:0] radius;
  logic [SPW-1:0]             span;
  logic [CV-1:0]              cols_eff;
  logic [RV-1:0]              rows_eff;
  logic [PW-1:0]              delay;

  logic [CV-1:0]  in_col;
  logic [IRW-1:0] in_row;
  logic [RGW-1:0] in_ring;
  logic [PW-1:0]  pos;
  logic [CV-1:0]  out_col;
  logic [RV-1:0]  out_row;
  logic [RGW-1:0] out_ring;
  logic           out_last;
  logic           out_last_q;

  logic signed [XW-1:0] x_base;
  logic signed [XW-1:0] x_cur;
  logic signed [YW-1:0] y_cur;
  logic [RGW-1:0]       scan_ring;
  logic [RGW-1:0]       ring_start;
  logic [SPW-1:0]       dx_cnt;
  logic [SPW-1:0]       dy_cnt;
  logic                 in_win;

  logic [PX-1:0] mem [DEPTH];
  logic [PX-1:0] rd_data;
  logic          rd_valid;

  logic [PX-1:0] s     [WIN];
  logic [PX-1:0] s_ins [WIN];
  logic [WIN-1:0] gt;
  logic [NW-1:0] n;
  logic [NW-1:0] sh_cnt;
  logic [NW-1:0] k;
  logic [PX:0]   mid_sum;
  logic [PX-1:0] mid_b;

  // effective configuration
  always_comb begin
    if ((window_size >> 1) > medf_pkg::WS_W'(RMAX)) begin
      radius = medf_pkg::RAD_W'(RMAX);
    end else begin
      radius = medf_pkg::RAD_W'(window_size >> 1);
    end
    span = {radius, 1'b0};
    if (image_cols == '0) begin
      cols_eff = CV'(1);
    end else if (32'(image_cols) > 32'(MAX_COLS)) begin
      cols_eff = CV'(MAX_COLS);
    end else begin
      cols_eff = CV'(image_cols);
    end
    if (image_rows == '0) begin
      rows_eff = RV'(1);
    end else if (32'(image_rows) > 32'(MAX_ROWS)) begin
      rows_eff = RV'(MAX_ROWS);
    end else begin
      rows_eff = RV'(image_rows);
    end
    delay = PW'(radius) * PW'(cols_eff) + PW'(radius);
  end

  assign out_last = (({1'b0, out_row} + 1'b1) >= {1'b0, rows_eff})
                 && (({1'b0, out_col} + 1'b1) >= {1'b0, cols_eff});

  always_comb begin
    if ({1'b0, out_ring} >= (RGW + 1)'(radius)) begin
      ring_start = RGW'({1'b0, out_ring} - (RGW + 1)'(radius));
    end else begin
      ring_start = RGW'({1'b0, out_ring} + (RGW + 1)'(RING) - (RGW + 1)'(radius));
    end
  end

  assign in_win = (y_cur >= 0) && (y_cur < $signed(YW'(rows_eff)))
               && (x_cur >= 0) && (x_cur < $signed(XW'(cols_eff)));

  assign status.emit      = pos >= delay;
  assign status.scan_last = (dx_cnt == span) && (dy_cnt == span);

  // config and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= medf_pkg::WS_RESET;
      image_cols  <= medf_pkg::COLS_RESET;
      image_rows  <= medf_pkg::ROWS_RESET;
      in_col      <= '0;
      in_row      <= '0;
      in_ring     <= '0;
      pos         <= '0;
      out_col     <= '0;
      out_row     <= '0;
      out_ring    <= '0;
    end else if (cfg_write) begin
      if (cfg_index == medf_pkg::REG_WINDOW_SIZE || cfg_index == medf_pkg::REG_IMAGE_COLS
          || cfg_index == medf_pkg::REG_IMAGE_ROWS) begin
        in_col   <= '0;
        in_row   <= '0;
        in_ring  <= '0;
        pos      <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_ring <= '0;
      end
      case (cfg_index)
        medf_pkg::REG_WINDOW_SIZE: window_size <= cfg_data[medf_pkg::WS_W-1:0];
        medf_pkg::REG_IMAGE_COLS:  image_cols  <= cfg_data;
        medf_pkg::REG_IMAGE_ROWS:  image_rows  <= cfg_data;
        default: begin
        end
      endcase
    end else if (cmd.accept) begin
      if (status.emit && out_last) begin
        in_col   <= '0;
        in_row   <= '0;
        in_ring  <= '0;
        pos      <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_ring <= '0;
      end else begin
        pos <= pos + 1'b1;
        if (({1'b0, in_col} + 1'b1) >= {1'b0, cols_eff}) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
          in_ring <= (in_ring == RGW'(RING - 1)) ? '0 : in_ring + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (status.emit) begin
          if (({1'b0, out_col} + 1'b1) >= {1'b0, cols_eff}) begin
            out_col  <= '0;
            out_row  <= out_row + 1'b1;
            out_ring <= (out_ring == RGW'(RING - 1)) ? '0 : out_ring + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // window scan position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_base     <= $signed(XW'(out_col)) - $signed(XW'(radius));
      x_cur      <= $signed(XW'(out_col)) - $signed(XW'(radius));
      y_cur      <= $signed(YW'(out_row)) - $signed(YW'(radius));
      scan_ring  <= ring_start;
      dx_cnt     <= '0;
      dy_cnt     <= '0;
      out_last_q <= out_last;
    end else if (cmd.scan) begin
      if (dx_cnt == span) begin
        dx_cnt    <= '0;
        x_cur     <= x_base;
        dy_cnt    <= dy_cnt + 1'b1;
        y_cur     <= y_cur + 1'b1;
        scan_ring <= (scan_ring == RGW'(RING - 1)) ? '0 : scan_ring + 1'b1;
      end else begin
        dx_cnt <= dx_cnt + 1'b1;
        x_cur  <= x_cur + 1'b1;
      end
    end
  end

  // row ring memory
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_row < IRW'(rows_eff))) begin
      mem[{in_ring, in_col[CW-1:0]}] <= (command == medf_pkg::CMD_PIXEL) ? pixel_in : '0;
    end
    if (cmd.scan) begin
      rd_data <= mem[{scan_ring, x_cur[CW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan && in_win;
    end
  end

  // insertion into the sorted list, unused slots count as above every value
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      gt[i] = (NW'(i) >= n) || (s[i] > rd_data);
    end
    s_ins[0] = gt[0] ? rd_data : s[0];
    for (int i = 1; i < WIN; i++) begin
      if (!gt[i]) begin
        s_ins[i] = s[i];
      end else if (!gt[i-1]) begin
        s_ins[i] = rd_data;
      end else begin
        s_ins[i] = s[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n      <= '0;
      sh_cnt <= '0;
    end else if (cmd.accept) begin
      n      <= '0;
      sh_cnt <= '0;
    end else if (rd_valid) begin
      n <= n + 1'b1;
    end else if (cmd.shift) begin
      sh_cnt <= sh_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      s <= s_ins;
    end else if (cmd.shift) begin
      for (int i = 0; i < WIN - 1; i++) begin
        s[i] <= s[i+1];
      end
    end
  end

  // middle element(s) brought to the head of the list
  assign k = n[0] ? (n >> 1) : ((n >> 1) - 1'b1);
  assign status.sel_done = (sh_cnt == k);
  assign mid_b   = n[0] ? s[0] : s[I1];
  assign mid_sum = {1'b0, s[0]} + {1'b0, mid_b} + 1'b1;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_out <= mid_sum[PX:1];
      frame_end <= out_last_q;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

### design/median_window_filter.sv
`timescale 1ns / 1ps
// sequence: a beat that yields no result is only taken; a beat with a result runs
// the window scan (W = 2*radius+1, one memory read per position), a drain state,
// the select shifts over the n pixels inside the clipped window and the output
// register load; one beat at a time, the scan using the single memory read port
// reset: synchronous, clears counters, handshake state and config to 3 / 640 / 480;
// the row ring memory is not cleared
// ----------------------------------------------------------------------------
// median_window_filter
// streaming 2-D median over a clipped square window, raster order in and out
// ----------------------------------------------------------------------------
module median_window_filter #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_WINDOW = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [medf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [medf_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [medf_pkg::PIX_W-1:0]      pixel_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [medf_pkg::PIX_W-1:0]      pixel_out,
  output logic                            frame_end
);

  medf_pkg::medf_cmd_t    cmd;
  medf_pkg::medf_status_t status;

  medf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  medf_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .pixel_in  (pixel_in),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pixel_out (pixel_out),
    .frame_end (frame_end),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
